FILE: hw/rtl/csfw_pkg.sv
// Package for the counting semaphore with a first-come waiter queue.
// Holds sizes, operation and result codes, payload structs and the
// control/status bundles shared by the controller and the datapath.
package csfw_pkg;

	localparam int WAIT_DEPTH    = 16;
	localparam int PROCESS_COUNT = 64;

	localparam int KEY_W  = 32;
	localparam int REQ_W  = 6;
	localparam int KIND_W = 2;
	localparam int STAT_W = 3;

	localparam int IDX_W  = $clog2(WAIT_DEPTH);
	localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
	localparam int SUM_W  = IDX_W + 1;

	// Requesters that own a halt mark
	localparam int MARK_COUNT = (PROCESS_COUNT < (1 << REQ_W)) ? PROCESS_COUNT : (1 << REQ_W);

	typedef enum logic [KIND_W-1:0] {
		KIND_GET  = 2'd0,
		KIND_TRY  = 2'd1,
		KIND_PUT  = 2'd2,
		KIND_HALT = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		RS_GRANTED  = 3'd0,
		RS_REFUSED  = 3'd1,
		RS_QUEUED   = 3'd2,
		RS_WOKEN    = 3'd3,
		RS_ZERO     = 3'd4,
		RS_OVERFLOW = 3'd5,
		RS_FULL     = 3'd6,
		RS_HALT     = 3'd7
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [REQ_W-1:0]  requester;
		logic [KEY_W-1:0]  key_count;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [REQ_W-1:0]  target;
		logic [KEY_W-1:0]  keys_free;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [REQ_W-1:0] who;
		logic [KEY_W-1:0] keys;
	} waiter_t;

	localparam int WAITER_W = $bits(waiter_t);

	// Controller to datapath
	typedef struct packed {
		logic cap;
		logic exec;
		logic walk;
		logic flush;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk_go;
		logic walk_stop;
		logic walk_last;
	} dp_stat_t;

endpackage

FILE: hw/rtl/csfw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module csfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/csfw_ctrl.sv
// Sequencing state machine for the semaphore: accept, execute, queue walk, flush.
// Depends on csfw_pkg for the command and status bundles.
module csfw_ctrl import csfw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     busy,
	output logic     cfg_ready
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = stat.walk_go ? ST_WALK : ST_FLUSH;
			end
			ST_WALK: begin
				if (stat.walk_stop || stat.walk_last) begin
					state_d = ST_FLUSH;
				end else begin
					// head moved: wait for the RAM to read the new head
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_WALK;
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	assign cmd.cap   = (state_q == ST_IDLE) && start;
	assign cmd.exec  = (state_q == ST_EXEC);
	assign cmd.walk  = (state_q == ST_WALK);
	assign cmd.flush = (state_q == ST_FLUSH);

	a_flush_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_WALK))
		else $error("flush without a preceding execute or walk step");

	a_accept_goes_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> cmd.exec)
		else $error("accepted item not executed in the next cycle");

	a_walk_needs_go: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && !stat.walk_go |=> !cmd.walk)
		else $error("queue walk started without a successful put");

endmodule

FILE: hw/rtl/csfw_datapath.sv
// Datapath: free key counter, waiter queue (RAM), halt marks, pending result and output register.
// Depends on csfw_pkg and csfw_ram.
module csfw_datapath import csfw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_cmd_t         cmd,
	output dp_stat_t         stat,
	input  item_t            item,
	input  logic             cfg_we,
	input  logic [KEY_W-1:0] cfg_data,
	output logic             done,
	output result_t          result
);

	item_t                   item_q;
	logic [KEY_W-1:0]        free_q;
	logic [IDX_W-1:0]        head_q;
	logic [FILL_W-1:0]       fill_q;
	logic [MARK_COUNT-1:0]   marks_q;
	result_t                 pend_q;
	logic                    pend_v_q;
	logic                    done_q;
	result_t                 result_q;

	waiter_t                 head_entry;
	waiter_t                 new_entry;
	logic [SUM_W-1:0]        tail_sum;
	logic [IDX_W-1:0]        tail_idx;
	logic [IDX_W-1:0]        head_next;
	logic [KEY_W:0]          put_sum;
	logic                    head_halted;
	logic                    too_big;
	logic                    req_marked;

	logic                    gen;
	logic [STAT_W-1:0]       gen_status;
	logic [REQ_W-1:0]        gen_target;
	logic [KEY_W-1:0]        gen_keys;
	logic [KEY_W-1:0]        free_d;
	logic                    enq;
	logic                    adv;
	logic                    mark_set;
	logic                    walk_go;

	// Queue storage: write at tail, read continuously at head
	assign tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
	assign tail_idx = (tail_sum >= SUM_W'(WAIT_DEPTH)) ?
		IDX_W'(tail_sum - SUM_W'(WAIT_DEPTH)) : IDX_W'(tail_sum);
	assign head_next = (head_q == IDX_W'(WAIT_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

	assign new_entry.who  = item_q.requester;
	assign new_entry.keys = item_q.key_count;

	csfw_ram #(
		.WIDTH(WAITER_W),
		.DEPTH(WAIT_DEPTH)
	) u_queue (
		.clk    (clk),
		.wr_en  (enq),
		.wr_addr(tail_idx),
		.wr_data(new_entry),
		.rd_addr(head_q),
		.rd_data(head_entry)
	);

	assign head_halted = (int'(head_entry.who) < MARK_COUNT) && marks_q[head_entry.who];
	assign too_big     = head_entry.keys > free_q;
	assign req_marked  = (int'(item_q.requester) < MARK_COUNT);
	assign put_sum     = {1'b0, free_q} + {1'b0, item_q.key_count};

	always_comb begin
		gen        = 1'b0;
		gen_status = RS_GRANTED;
		gen_target = item_q.requester;
		gen_keys   = free_q;
		free_d     = free_q;
		enq        = 1'b0;
		adv        = 1'b0;
		mark_set   = 1'b0;
		walk_go    = 1'b0;
		if (cmd.exec) begin
			gen = 1'b1;
			if (item_q.kind == KIND_HALT) begin
				mark_set   = req_marked;
				gen_status = RS_HALT;
			end else if (item_q.key_count == '0) begin
				gen_status = RS_ZERO;
			end else if (item_q.kind == KIND_PUT) begin
				if (put_sum[KEY_W]) begin
					gen_status = RS_OVERFLOW;
				end else begin
					free_d   = put_sum[KEY_W-1:0];
					gen_keys = put_sum[KEY_W-1:0];
					walk_go  = (fill_q != '0);
				end
			end else if (fill_q == '0 && free_q >= item_q.key_count) begin
				free_d   = free_q - item_q.key_count;
				gen_keys = free_q - item_q.key_count;
			end else if (item_q.kind == KIND_TRY) begin
				gen_status = RS_REFUSED;
			end else if (fill_q == FILL_W'(WAIT_DEPTH)) begin
				gen_status = RS_FULL;
			end else begin
				enq        = 1'b1;
				gen_status = RS_QUEUED;
			end
		end else if (cmd.walk) begin
			// drop a halted head silently, wake a head that fits, else stop
			adv = head_halted || !too_big;
			if (!head_halted && !too_big) begin
				gen        = 1'b1;
				gen_status = RS_WOKEN;
				gen_target = head_entry.who;
				free_d     = free_q - head_entry.keys;
				gen_keys   = free_q - head_entry.keys;
			end
		end
	end

	assign stat.walk_go   = walk_go;
	assign stat.walk_stop = !head_halted && too_big;
	assign stat.walk_last = (fill_q == FILL_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= '0;
			head_q   <= '0;
			fill_q   <= '0;
			marks_q  <= '0;
			pend_v_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				free_q <= cfg_data;
				head_q <= '0;
				fill_q <= '0;
			end else begin
				free_q <= free_d;
				if (enq) begin
					fill_q <= fill_q + FILL_W'(1);
				end else if (adv) begin
					fill_q <= fill_q - FILL_W'(1);
					head_q <= head_next;
				end
			end
			if (mark_set) begin
				marks_q[item_q.requester] <= 1'b1;
			end
			// a new result pushes the held one out as not-last
			if (gen) begin
				pend_v_q <= 1'b1;
				done_q   <= pend_v_q;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
				done_q   <= pend_v_q;
			end else begin
				done_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= item;
		end
		if (gen || cmd.flush) begin
			result_q.status    <= pend_q.status;
			result_q.target    <= pend_q.target;
			result_q.keys_free <= pend_q.keys_free;
			result_q.last      <= cmd.flush;
		end
		if (gen) begin
			pend_q.status    <= gen_status;
			pend_q.target    <= gen_target;
			pend_q.keys_free <= gen_keys;
			pend_q.last      <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WAIT_DEPTH))
		else $error("waiter queue fill beyond depth");

	a_flush_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> done_q && result_q.last)
		else $error("flush did not deliver a final result");

	a_stop_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk && stat.walk_stop && !cfg_we |=>
		fill_q == $past(fill_q) && head_q == $past(head_q))
		else $error("queue moved on a stopped walk");

	a_only_put_multi: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !result_q.last |->
		(result_q.status == RS_GRANTED || result_q.status == RS_WOKEN))
		else $error("non-final result from an item other than put");

endmodule

FILE: hw/rtl/counting_semaphore_fifo_waiters_core.sv
// Counting semaphore with first-come waiter queue: top level.
// Sequence: the start transfer captures the item, an execute step follows and a flush step ends it;
// get, try get and halt give one result and the block takes no new item until busy falls.
// A put that visits queued waiters holds busy through the queue walk (one RAM read per waiter).
// Results are one-cycle strobes; the receiver cannot stall. Reset clears free keys to 0,
// empties the queue and clears all halt marks; there is no clearing pass.
module counting_semaphore_fifo_waiters_core import csfw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [KEY_W-1:0] cfg_data,
	output logic             done,
	output result_t          result
);

	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic     cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	csfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.cfg_ready(cfg_ready)
	);

	csfw_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.item    (item),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.done    (done),
		.result  (result)
	);

endmodule
